[design/u2a_pkg.sv]
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and constants for the unsigned-to-ASCII converter
// Request and result payload structs, widths, FSM commands and status.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int DIGIT_W     = 4;
  localparam int CAP_W       = 8;
  localparam int NEED_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 2);
  localparam int BIT_CNT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int BCD_W       = DIGIT_W * MAX_DIGITS;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;  // 'A'
  localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   radix_hex;
    logic [CAP_W-1:0]       buffer_capacity;
  } u2a_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              fits;
    logic [NEED_W-1:0] needed_size;
  } u2a_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic shift;     // one double-dabble step
    logic count;     // find digit count and fit
    logic load_out;  // load the first result
    logic advance;   // step to the next lower digit
  } u2a_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_hex;
    logic out_last;
  } u2a_sts_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_RADIX);
    end
    return c;
  endfunction

endpackage

[design/u2a_ctrl.sv]
// ----------------------------------------------------------------------------
// u2a_ctrl: conversion sequencer
// Steps a request through capture, binary-to-BCD shifting, digit count and
// result emission, and drives both channel handshakes.
// ----------------------------------------------------------------------------
module u2a_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output u2a_pkg::u2a_cmd_t cmd,
  input  u2a_pkg::u2a_sts_t sts
);
  import u2a_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_WIDTH - 1);

  logic [2:0]           state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        bit_cnt_nxt = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.is_hex) begin
          state_nxt = ST_COUNT;
        end else begin
          cmd.shift   = 1'b1;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (bit_cnt_r == BIT_LAST) begin
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (sts.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule

[design/u2a_dp.sv]
// ----------------------------------------------------------------------------
// u2a_dp: conversion datapath
// Double-dabble BCD shifter, direct nibble load for hex, digit counter and
// the registered result word.
// ----------------------------------------------------------------------------
module u2a_dp (
  input  logic              clk,
  input  u2a_pkg::u2a_in_t  in_data,
  input  u2a_pkg::u2a_cmd_t cmd,
  output u2a_pkg::u2a_sts_t sts,
  output u2a_pkg::u2a_out_t out_data
);
  import u2a_pkg::*;

  logic [DIGIT_W-1:0]     digits_r [MAX_DIGITS];
  logic [DIGIT_W-1:0]     digits_nxt [MAX_DIGITS];
  logic [DIGIT_W-1:0]     adj [MAX_DIGITS];
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   is_hex_r;
  logic [CAP_W-1:0]       cap_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_enc;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       idx_dec;
  logic                   fits_r;
  logic [NEED_W-1:0]      needed;
  u2a_out_t               out_r;
  logic [BCD_W+VALUE_WIDTH-1:0] hex_ext;

  assign hex_ext = {{BCD_W{1'b0}}, in_data.value};
  assign needed  = NEED_W'(count_r + 1'b1);
  assign idx_dec = idx_r - 1'b1;

  // add-3 correction, then shift the whole BCD word left one bit
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digits_r[i] >= 4'd5) ? digits_r[i] + 4'd3 : digits_r[i];
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (i == 0) begin
        digits_nxt[i] = {adj[i][DIGIT_W-2:0], value_r[VALUE_WIDTH-1]};
      end else begin
        digits_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
    end
  end

  // highest nonzero digit sets the count; zero still gives one digit
  always_comb begin
    count_enc = CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits_r[i] != '0) begin
        count_enc = CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= in_data.value;
      is_hex_r <= in_data.radix_hex;
      cap_r    <= in_data.buffer_capacity;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits_r[i] <= in_data.radix_hex ? hex_ext[DIGIT_W*i +: DIGIT_W] : '0;
      end
    end else if (cmd.shift) begin
      value_r  <= {value_r[VALUE_WIDTH-2:0], 1'b0};
      digits_r <= digits_nxt;
    end
    if (cmd.count) begin
      count_r <= count_enc;
      fits_r  <= (cap_r > CAP_W'(count_enc));
      idx_r   <= IDX_W'(count_enc - 1'b1);
    end
    if (cmd.load_out) begin
      if (fits_r) begin
        out_r.digit_char <= digit_ascii(digits_r[idx_r]);
        out_r.last_digit <= (idx_r == '0);
        out_r.fits       <= 1'b1;
      end else begin
        out_r.digit_char <= '0;
        out_r.last_digit <= 1'b1;
        out_r.fits       <= 1'b0;
      end
      out_r.needed_size <= needed;
    end else if (cmd.advance) begin
      idx_r            <= idx_dec;
      out_r.digit_char <= digit_ascii(digits_r[idx_dec]);
      out_r.last_digit <= (idx_dec == '0);
    end
  end

  assign sts.is_hex   = is_hex_r;
  assign sts.out_last = out_r.last_digit;
  assign out_data     = out_r;

endmodule

[design/uint_to_ascii_digits.sv]
// A decimal request passes through capture, the bit-serial double-dabble
// shift steps, digit count and first-result load; hex skips the shifting.
// Throughput: one request at a time; a new request is taken only once the
// sequencer is back in idle after the last result of the previous one, and
// results leave at one per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) returns the sequencer to idle; no result pends.
// ----------------------------------------------------------------------------
// uint_to_ascii_digits: unsigned binary to ASCII decimal or hex digits
// Emits digits most significant first with a last flag, or one failure
// result with the needed size when the caller's buffer is too small.
// ----------------------------------------------------------------------------
module uint_to_ascii_digits (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u2a_pkg::u2a_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output u2a_pkg::u2a_out_t out_data
);
  import u2a_pkg::*;

  // Command and status between sequencer and datapath
  u2a_cmd_t cmd;
  u2a_sts_t sts;

  // Sequencer: takes a request only when idle, then walks through the
  // conversion; the output register holds each result while stalled and
  // advances to the next lower digit on each accepted result but the last.
  u2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: decimal digits come from a shift-and-add-3 BCD converter fed
  // one value bit per cycle; hex digits are the value's nibbles loaded
  // directly. The digit count is the position of the top nonzero digit.
  u2a_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[sim/tb_uint_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// tb_uint_to_ascii_digits: self-checking bench for the digit converter
// Feeds conversion requests through a valid/stall driver and checks every
// digit result against an in-bench predictor, with random gaps and stalls on
// both sides and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_uint_to_ascii_digits;
  import u2a_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 200;   // more than one decimal request
  localparam int unsigned HOLD_CYCLES   = 600;   // long receiver hold-off
  localparam int unsigned HOLD_AFTER    = 120;   // requests taken before hold-off
  localparam int unsigned RANDOM_REQS   = 280;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned MAX_WAIT      = 19;
  localparam int unsigned DEC_BASE      = 10;
  localparam int unsigned HEX_BASE      = 16;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;  // 'A'

  // One queued request plus the idle cycles the sender inserts after it.
  typedef struct {
    u2a_in_t     req;
    int unsigned gap;
  } pending_req_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  u2a_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  u2a_out_t out_data;

  pending_req_t pending_q[$];     // requests not yet offered
  u2a_out_t     digit_exp_q[$];   // predicted results, oldest first

  int unsigned requests_taken = 0;
  int unsigned results_seen   = 0;
  int unsigned err_count      = 0;
  int unsigned cycle_count    = 0;

  // Receiver hold-off state, owned by its own process.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        rx_hold   = 1'b0;

  uint_to_ascii_digits i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the digit results of one request and append them to the
  // expectation queue: digits most significant first, or a single failure
  // result when digits plus terminator do not fit the caller's buffer.
  function automatic void predict_digits(input u2a_in_t req);
    logic [VALUE_WIDTH-1:0] rest;
    logic [VALUE_WIDTH-1:0] base;
    logic [CHAR_W-1:0]      txt [MAX_DIGITS];
    int unsigned            ndig;
    int unsigned            d;
    logic [NEED_W-1:0]      need;
    u2a_out_t               res;
    rest = req.value;
    base = req.radix_hex ? VALUE_WIDTH'(HEX_BASE) : VALUE_WIDTH'(DEC_BASE);
    ndig = 0;
    // Collect digits least significant first; zero still yields one digit.
    do begin
      d = int'(rest % base);
      txt[ndig] = (d < DEC_BASE) ? ASCII_ZERO + CHAR_W'(d)
                                 : ASCII_UPPER_A + CHAR_W'(d - DEC_BASE);
      rest = rest / base;
      ndig++;
    end while (rest != 0 && ndig < MAX_DIGITS);
    need = NEED_W'(ndig + 1);
    if (ndig >= req.buffer_capacity) begin
      res.digit_char  = '0;
      res.last_digit  = 1'b1;
      res.fits        = 1'b0;
      res.needed_size = need;
      digit_exp_q.push_back(res);
    end else begin
      for (int k = 0; k < ndig; k++) begin
        res.digit_char  = txt[ndig - 1 - k];
        res.last_digit  = (k == ndig - 1);
        res.fits        = 1'b1;
        res.needed_size = need;
        digit_exp_q.push_back(res);
      end
    end
  endfunction

  function automatic void log_mismatch(input bit orphan, input u2a_out_t exp_res,
                                       input u2a_out_t got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      if (orphan) begin
        $display("[%0d] unexpected result: char=%h last=%b fits=%b need=%0d",
                 cycle_count, got.digit_char, got.last_digit, got.fits,
                 got.needed_size);
      end else begin
        $display("[%0d] result %0d mismatch: exp char=%h last=%b fits=%b need=%0d",
                 cycle_count, results_seen, exp_res.digit_char, exp_res.last_digit,
                 exp_res.fits, exp_res.needed_size);
        $display("            got char=%h last=%b fits=%b need=%0d",
                 got.digit_char, got.last_digit, got.fits, got.needed_size);
      end
    end
  endfunction

  function automatic void add_req(input logic [VALUE_WIDTH-1:0] value,
                                  input logic radix_hex,
                                  input logic [CAP_W-1:0] cap,
                                  input int unsigned gap);
    pending_req_t p;
    p.req.value           = value;
    p.req.radix_hex       = radix_hex;
    p.req.buffer_capacity = cap;
    p.gap                 = gap;
    pending_q.push_back(p);
  endfunction

  // Request driver: hold the payload while stalled, otherwise either idle
  // out the current gap or present the next pending request.
  always @(posedge clk) begin : drive_requests
    pending_req_t nxt;
    int unsigned  gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        requests_taken <= requests_taken + 1;
      end
      if (gap_left != 0 || pending_q.size() == 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end
        in_valid <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        in_data  <= nxt.req;
        in_valid <= 1'b1;
        gap_left = nxt.gap;
      end
    end
  end

  // Long hold-off: once enough requests went through, stall the output for
  // a long stretch so the block fills up and stalls its input.
  always @(posedge clk) begin : receiver_hold
    if (rst_n) begin
      if (!hold_done && requests_taken >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rx_hold   <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        rx_hold   <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted request, check every accepted result
  // against the oldest expectation, and draw the stall before the next one.
  // Every third block of fifty results runs with no random stall.
  always @(posedge clk) begin : check_results
    u2a_out_t    exp_res;
    int unsigned stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_digits(in_data);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (digit_exp_q.size() == 0) begin
          log_mismatch(1'b1, '0, out_data);
        end else begin
          exp_res = digit_exp_q.pop_front();
          if (out_data.digit_char  !== exp_res.digit_char ||
              out_data.last_digit  !== exp_res.last_digit ||
              out_data.fits        !== exp_res.fits ||
              out_data.needed_size !== exp_res.needed_size) begin
            log_mismatch(1'b0, exp_res, out_data);
          end
        end
        stall_left = ((results_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= rx_hold || (stall_left != 0);
    end
  end

  // Watchdog: end the run if it takes far longer than any correct run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0d] timeout, %0d results still expected", cycle_count,
               digit_exp_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run_test
    logic [VALUE_WIDTH-1:0] v;
    int unsigned            nbits;
    int unsigned            cap_mode;
    logic [CAP_W-1:0]       cap;
    int unsigned            gap;

    // Directed requests: zero, all-ones, radix corners, exact fit and
    // one-short capacities, zero capacity, saturated capacity.
    add_req(64'd0, 1'b0, 8'd2, $urandom_range(0, MAX_WAIT));
    add_req(64'd0, 1'b1, 8'd1, $urandom_range(0, MAX_WAIT));
    add_req(64'd0, 1'b0, 8'd0, $urandom_range(0, MAX_WAIT));
    add_req('1, 1'b0, 8'd21, $urandom_range(0, MAX_WAIT));
    add_req('1, 1'b0, 8'd20, $urandom_range(0, MAX_WAIT));
    add_req('1, 1'b1, 8'd17, $urandom_range(0, MAX_WAIT));
    add_req('1, 1'b1, 8'd16, $urandom_range(0, MAX_WAIT));
    add_req('1, 1'b0, 8'd255, $urandom_range(0, MAX_WAIT));
    add_req(64'd9, 1'b0, 8'd2, $urandom_range(0, MAX_WAIT));
    add_req(64'd10, 1'b0, 8'd3, $urandom_range(0, MAX_WAIT));
    add_req(64'd10, 1'b0, 8'd2, $urandom_range(0, MAX_WAIT));
    add_req(64'd15, 1'b1, 8'd2, $urandom_range(0, MAX_WAIT));
    add_req(64'd16, 1'b1, 8'd3, $urandom_range(0, MAX_WAIT));
    add_req(64'h0123_4567_89AB_CDEF, 1'b1, 8'd255, $urandom_range(0, MAX_WAIT));
    add_req(64'hFEDC_BA98_7654_3210, 1'b1, 8'd17, $urandom_range(0, MAX_WAIT));
    add_req(64'd9999999999999999999, 1'b0, 8'd20, $urandom_range(0, MAX_WAIT));
    add_req(64'd10000000000000000000, 1'b0, 8'd21, $urandom_range(0, MAX_WAIT));
    add_req(64'h8000_0000_0000_0000, 1'b0, 8'd21, $urandom_range(0, MAX_WAIT));
    add_req(64'h8000_0000_0000_0000, 1'b1, 8'd17, $urandom_range(0, MAX_WAIT));
    add_req(64'd1234567890, 1'b0, 8'd11, $urandom_range(0, MAX_WAIT));
    add_req(64'd1234567890, 1'b0, 8'd10, $urandom_range(0, MAX_WAIT));
    add_req(64'hA, 1'b1, 8'd255, $urandom_range(0, MAX_WAIT));

    // Random requests: spread the significant width so every digit count
    // shows up, and mix roomy, near-boundary and arbitrary capacities.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      nbits = $urandom_range(0, VALUE_WIDTH);
      v = {$urandom, $urandom};
      if (nbits < VALUE_WIDTH) begin
        v &= (VALUE_WIDTH'(1) << nbits) - 1;
      end
      cap_mode = $urandom_range(0, 9);
      if (cap_mode < 4) begin
        cap = ($urandom_range(0, 3) == 0) ? 8'd255 : CAP_W'($urandom_range(21, 255));
      end else if (cap_mode < 8) begin
        cap = CAP_W'($urandom_range(0, 21));
      end else begin
        cap = CAP_W'($urandom_range(0, 255));
      end
      gap = ((i % 50) >= 38) ? 0 : $urandom_range(0, MAX_WAIT);
      add_req(v, 1'($urandom_range(0, 1)), cap, gap);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: sample on the falling edge so the check sees settled state.
    do begin
      @(negedge clk);
    end while (pending_q.size() != 0 || in_valid || digit_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
design/u2a_pkg.sv
design/u2a_ctrl.sv
design/u2a_dp.sv
design/uint_to_ascii_digits.sv
sim/tb_uint_to_ascii_digits.sv
